@@ src/g6d_pkg.sv @@
// Shared types and constants for the graph6 edge stream decoder.
package g6d_pkg;

   // Width of vertex indexes and of the vertex count
   localparam int VERTEX_BITS = 18;

   // Character coding
   localparam int CHAR_BIAS     = 63;
   localparam int CHAR_TOP      = 126;
   localparam int LONG_MARK     = 126;
   localparam int BITS_PER_CHAR = 6;
   localparam int SIZE_CHARS    = 3;

   // Walk counter covers the bits of one character
   localparam int BIT_CNT_BITS = $clog2(BITS_PER_CHAR + 1);

   // Command queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_COUNT = 2'd0,
      KIND_EDGE  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_BAD   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_BAD   = 2'd0,
      OP_ORDER = 2'd1,
      OP_DATA  = 2'd2
   } cmd_op_type;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_SIZE   = 2'd1,
      PH_DATA   = 2'd2
   } front_phase_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       new_graph;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [VERTEX_BITS-1:0] first_vertex;
      logic [VERTEX_BITS-1:0] second_vertex;
      logic [VERTEX_BITS-1:0] vertex_count;
      logic                   last;
   } rsp_type;

   // Work for the back end: one per character that can give results
   typedef struct packed {
      cmd_op_type               op;
      logic [BITS_PER_CHAR-1:0] bits;
      logic [VERTEX_BITS-1:0]   order;
   } cmd_type;

endpackage

@@ src/g6d_front.sv @@
// Front end: accepts characters, decodes the header and size, issues commands.
module g6d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  g6d_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              push_valid,
   output g6d_pkg::cmd_type  push_data
);
   import g6d_pkg::*;

   front_phase_type        phase_ff, phase_in, base_phase;
   logic [1:0]             size_left_ff, size_left_in, base_size_left;
   logic [VERTEX_BITS-1:0] order_ff, order_in, base_order;
   logic                   accept;
   logic                   bad_char;
   logic [7:0]             biased;
   logic [BITS_PER_CHAR-1:0] value;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Character classification
   assign bad_char = (req_data.char_code < 8'(CHAR_BIAS)) ||
                     (req_data.char_code > 8'(CHAR_TOP));
   assign biased   = req_data.char_code - 8'(CHAR_BIAS);
   assign value    = biased[BITS_PER_CHAR-1:0];

   // A new graph restarts decode before the character is looked at
   always_comb begin
      if (req_data.new_graph) begin
         base_phase     = PH_HEADER;
         base_size_left = 2'd0;
         base_order     = '0;
      end else begin
         base_phase     = phase_ff;
         base_size_left = size_left_ff;
         base_order     = order_ff;
      end
   end

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      size_left_in = size_left_ff;
      order_in     = order_ff;
      if (accept) begin
         phase_in     = base_phase;
         size_left_in = base_size_left;
         order_in     = base_order;
         if (!bad_char) begin
            unique case (base_phase)
               PH_HEADER: begin
                  if (req_data.char_code == 8'(LONG_MARK)) begin
                     phase_in     = PH_SIZE;
                     size_left_in = 2'(SIZE_CHARS);
                     order_in     = '0;
                  end else begin
                     phase_in = PH_DATA;
                     order_in = VERTEX_BITS'(value);
                  end
               end
               PH_SIZE: begin
                  order_in     = (base_order << BITS_PER_CHAR) | VERTEX_BITS'(value);
                  size_left_in = base_size_left - 2'd1;
                  if (base_size_left == 2'd1) begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  phase_in = PH_DATA;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   // Command issue
   always_comb begin
      push_valid      = 1'b0;
      push_data.op    = OP_BAD;
      push_data.bits  = value;
      push_data.order = order_in;
      if (accept) begin
         if (bad_char) begin
            push_valid   = 1'b1;
            push_data.op = OP_BAD;
         end else begin
            unique case (base_phase)
               PH_HEADER: begin
                  push_valid   = (req_data.char_code != 8'(LONG_MARK));
                  push_data.op = OP_ORDER;
               end
               PH_SIZE: begin
                  push_valid   = (base_size_left == 2'd1);
                  push_data.op = OP_ORDER;
               end
               PH_DATA: begin
                  push_valid   = 1'b1;
                  push_data.op = OP_DATA;
               end
               default: begin
                  push_valid = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         size_left_ff <= 2'd0;
         order_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         size_left_ff <= size_left_in;
         order_ff     <= order_in;
      end
   end

endmodule

@@ src/g6d_queue.sv @@
// Short command queue between the front and back ends.
module g6d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  g6d_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output g6d_pkg::cmd_type  head_data
);
   import g6d_pkg::*;

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/g6d_back.sv @@
// Back end: walks the adjacency bits of each command and delivers results.
module g6d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  g6d_pkg::cmd_type  head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output g6d_pkg::rsp_type  rsp_data
);
   import g6d_pkg::*;

   // Walk state
   logic [VERTEX_BITS-1:0]  row_ff, row_in;
   logic [VERTEX_BITS-1:0]  col_ff, col_in;
   logic                    done_ff, done_in;
   logic [BIT_CNT_BITS-1:0] bit_left_ff, bit_left_in;
   logic                    first_ff, first_in;

   // Result held until it is known whether it is the last of its character
   logic    pend_valid_ff, pend_valid_in;
   rsp_type pend_ff, pend_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                    step_res, step_end, step_go;
   rsp_type                 step_rsp;
   logic [VERTEX_BITS-1:0]  row_step, col_step;
   logic                    done_step;
   logic [BIT_CNT_BITS-1:0] bit_left_step;
   logic [BIT_CNT_BITS-1:0] bit_idx;
   logic [VERTEX_BITS-1:0]  row_inc;
   logic                    out_free, pend_out;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign bit_idx = bit_left_ff - BIT_CNT_BITS'(1);
   assign row_inc = row_ff + VERTEX_BITS'(1);

   // One step of the current command: at most one result
   always_comb begin
      step_res               = 1'b0;
      step_end               = 1'b0;
      step_rsp.kind          = KIND_BAD;
      step_rsp.first_vertex  = '0;
      step_rsp.second_vertex = '0;
      step_rsp.vertex_count  = head_data.order;
      step_rsp.last          = 1'b0;
      row_step               = row_ff;
      col_step               = col_ff;
      done_step              = done_ff;
      bit_left_step          = bit_left_ff;
      if (head_data.op == OP_BAD) begin
         step_res      = 1'b1;
         step_end      = 1'b1;
         step_rsp.kind = KIND_BAD;
      end else if (head_data.op == OP_ORDER && first_ff) begin
         // Count result, then the walk restarts at the first column
         step_res      = 1'b1;
         step_rsp.kind = KIND_COUNT;
         row_step      = '0;
         col_step      = VERTEX_BITS'(1);
         done_step     = 1'b0;
         bit_left_step = '0;
         step_end      = (head_data.order > VERTEX_BITS'(1));
      end else if (done_ff) begin
         step_end = 1'b1;
      end else if (col_ff >= head_data.order) begin
         // Column index reached the vertex count
         step_res      = 1'b1;
         step_rsp.kind = KIND_DONE;
         done_step     = 1'b1;
         step_end      = 1'b1;
      end else begin
         // One adjacency bit, most significant first
         step_res               = head_data.bits[bit_idx];
         step_rsp.kind          = KIND_EDGE;
         step_rsp.first_vertex  = row_ff;
         step_rsp.second_vertex = col_ff;
         bit_left_step          = bit_idx;
         if (row_inc == col_ff) begin
            row_step = '0;
            col_step = col_ff + VERTEX_BITS'(1);
         end else begin
            row_step = row_inc;
         end
         step_end = (bit_left_ff == BIT_CNT_BITS'(1)) && (col_step < head_data.order);
      end
      step_rsp.last = step_end;
   end

   // A step needs room for its result in the holding register
   assign step_go  = head_valid && (!step_res || !pend_valid_ff || out_free);
   assign pend_out = pend_valid_ff && out_free && (pend_ff.last || (step_go && step_res));
   assign pop      = step_go && step_end;

   // Walk state update
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      done_in     = done_ff;
      bit_left_in = bit_left_ff;
      first_in    = first_ff;
      if (step_go) begin
         row_in  = row_step;
         col_in  = col_step;
         done_in = done_step;
         if (step_end) begin
            bit_left_in = BIT_CNT_BITS'(BITS_PER_CHAR);
            first_in    = 1'b1;
         end else begin
            bit_left_in = bit_left_step;
            first_in    = 1'b0;
         end
      end
   end

   // Holding register and output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (pend_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pend_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (step_go && step_res) begin
         pend_valid_in = 1'b1;
         pend_in       = step_rsp;
      end else if (pend_out) begin
         pend_valid_in = 1'b0;
      end else if (step_go && step_end) begin
         pend_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= VERTEX_BITS'(1);
         done_ff       <= 1'b0;
         bit_left_ff   <= BIT_CNT_BITS'(BITS_PER_CHAR);
         first_ff      <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         done_ff       <= done_in;
         bit_left_ff   <= bit_left_in;
         first_ff      <= first_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ src/graph6_edge_stream_decoder.sv @@
// A command's result passes from the command queue through the holding register to the
//   output register before it is on rsp.
// Throughput: '~' and earlier size bytes give no back-end command; bad characters and counts
//   take one walk step (two for a count of 0 or 1); a data character takes up to seven (six
//   bits plus completion), one per cycle in the bit walker while the holding register has room.
// Reset: decode expects a header byte, the command queue empties, no result is held.
module graph6_edge_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  g6d_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output g6d_pkg::rsp_type  rsp_data
);
   import g6d_pkg::*;

   logic    push_valid;
   cmd_type push_data;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_data;
   logic    pop;

   // Character decode
   g6d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Decoupling queue
   g6d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Bit walk and result delivery
   g6d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
